// ----- design/dnsd_pkg.sv -----
// ----------------------------------------------------------------------------
// dnsd_pkg
// Shared types and constants of the dns name decompressor.
// ----------------------------------------------------------------------------
package dnsd_pkg;

  localparam int MESSAGE_BYTES = 512;
  localparam int MAX_JUMPS     = 16;
  localparam int ADDR_W        = $clog2(MESSAGE_BYTES);
  localparam int POS_W         = 10;
  localparam int JUMP_W        = 5;
  localparam int BUILT_W       = 9;

  localparam logic [7:0]  PREFIX_MASK = 8'hc0;
  localparam logic [13:0] TARGET_MASK = 14'h3fff;
  localparam int          LABEL_LIMIT = 63;
  localparam int          NAME_LIMIT  = 255;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_START = 2'd1,
    REQ_NEXT  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_LABEL = 2'd1,
    KIND_END   = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ERR_PAST_END    = 4'd0,
    ERR_PTR_CUT     = 4'd1,
    ERR_FORWARD     = 4'd2,
    ERR_JUMPS       = 4'd3,
    ERR_RESERVED    = 4'd4,
    ERR_LONG_LABEL  = 4'd5,
    ERR_LABEL_PAST  = 4'd6,
    ERR_LONG_NAME   = 4'd7,
    ERR_IDLE        = 4'd8
  } error_e;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

// ----- design/dns_name_decompressor.sv -----
// ----------------------------------------------------------------------------
// dns_name_decompressor
// Byte store plus a name walker that follows compression pointers.
// ----------------------------------------------------------------------------
// Every accepted item gets exactly one result, shown on the result ports for
// a single cycle with done_o; the receiver cannot stall, so capture it then.
// Load, start and unused request items, and a next-label item with no decode
// active, answer the cycle after acceptance and keep busy low, so one such
// item can be taken every cycle. Any other next-label item passes the fetch
// and label-byte states, then the pointer-byte and fetch states again for
// each compression pointer it follows (at most 16 per name), paced by the
// store's single registered read port; busy is high until its result appears.
module dns_name_decompressor (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] req_type_i,
  input  logic [9:0] position_i,
  input  logic [7:0] byte_value_i,
  input  logic [9:0] message_length_i,
  output logic       done_o,
  output logic [1:0] kind_o,
  output logic [8:0] label_start_o,
  output logic [5:0] label_length_o,
  output logic [7:0] name_length_o,
  output logic [9:0] resume_offset_o,
  output logic [3:0] error_code_o
);
  import dnsd_pkg::*;

  mem_req_t   mem_req;
  logic [7:0] rdata;

  dnsd_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  dnsd_walker u_walker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .req_type_i       (req_type_i),
    .position_i       (position_i),
    .byte_value_i     (byte_value_i),
    .message_length_i (message_length_i),
    .mem_req_o        (mem_req),
    .rdata_i          (rdata),
    .done_o           (done_o),
    .kind_o           (kind_o),
    .label_start_o    (label_start_o),
    .label_length_o   (label_length_o),
    .name_length_o    (name_length_o),
    .resume_offset_o  (resume_offset_o),
    .error_code_o     (error_code_o)
  );

endmodule

// ----- design/dnsd_store.sv -----
// ----------------------------------------------------------------------------
// dnsd_store
// Message byte store: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dnsd_store (
  input  logic              clk_i,
  input  dnsd_pkg::mem_req_t req_i,
  output logic [7:0]        rdata_o
);
  import dnsd_pkg::*;

  logic [7:0] mem [MESSAGE_BYTES];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/dnsd_walker.sv -----
// ----------------------------------------------------------------------------
// dnsd_walker
// Request sequencer: loads, decode state and the pointer/label walk.
// ----------------------------------------------------------------------------
module dnsd_walker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                req_type_i,
  input  logic [dnsd_pkg::POS_W-1:0] position_i,
  input  logic [7:0]                byte_value_i,
  input  logic [dnsd_pkg::POS_W-1:0] message_length_i,
  output dnsd_pkg::mem_req_t         mem_req_o,
  input  logic [7:0]                rdata_i,
  output logic                      done_o,
  output logic [1:0]                kind_o,
  output logic [8:0]                label_start_o,
  output logic [5:0]                label_length_o,
  output logic [7:0]                name_length_o,
  output logic [9:0]                resume_offset_o,
  output logic [3:0]                error_code_o
);
  import dnsd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_WAIT_LB,
    ST_WAIT_LO
  } state_e;

  state_e             state_q, state_d;
  logic [POS_W-1:0]   len_q, len_d;
  logic [POS_W-1:0]   walk_q, walk_d;
  logic [POS_W-1:0]   resume_q, resume_d;
  logic               ptr_q, ptr_d;
  logic [JUMP_W-1:0]  jump_q, jump_d;
  logic [BUILT_W-1:0] built_q, built_d;
  logic               active_q, active_d;
  logic [7:0]         lb_q, lb_d;

  logic               done_q, done_d;
  logic [1:0]         kind_q, kind_d;
  logic [8:0]         lstart_q, lstart_d;
  logic [5:0]         llen_q, llen_d;
  logic [7:0]         nlen_q, nlen_d;
  logic [9:0]         rsm_q, rsm_d;
  logic [3:0]         err_q, err_d;

  logic [13:0]        target;
  logic [POS_W:0]     label_end;
  logic [POS_W-1:0]   name_sum;
  logic [POS_W-1:0]   walk_inc;

  assign target    = {lb_q[5:0], rdata_i} & TARGET_MASK;
  assign walk_inc  = walk_q + POS_W'(1);
  assign label_end = {1'b0, walk_inc} + (POS_W+1)'(rdata_i);
  assign name_sum  = POS_W'(built_q) + POS_W'(rdata_i) + POS_W'(1);

  always_comb begin
    state_d  = state_q;
    len_d    = len_q;
    walk_d   = walk_q;
    resume_d = resume_q;
    ptr_d    = ptr_q;
    jump_d   = jump_q;
    built_d  = built_q;
    active_d = active_q;
    lb_d     = lb_q;
    done_d   = 1'b0;
    kind_d   = KIND_ACK;
    lstart_d = '0;
    llen_d   = '0;
    nlen_d   = '0;
    rsm_d    = '0;
    err_d    = '0;

    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = position_i[ADDR_W-1:0];
    mem_req_o.wdata = byte_value_i;
    mem_req_o.raddr = walk_q[ADDR_W-1:0];

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (req_type_i)
            REQ_LOAD: begin
              mem_req_o.we = (position_i < POS_W'(MESSAGE_BYTES));
              done_d       = 1'b1;
            end
            REQ_START: begin
              len_d    = (message_length_i > POS_W'(MESSAGE_BYTES)) ?
                         POS_W'(MESSAGE_BYTES) : message_length_i;
              walk_d   = position_i;
              resume_d = '0;
              ptr_d    = 1'b0;
              jump_d   = '0;
              built_d  = '0;
              active_d = 1'b1;
              done_d   = 1'b1;
            end
            REQ_NEXT: begin
              if (!active_q) begin
                done_d = 1'b1;
                kind_d = KIND_ERROR;
                err_d  = ERR_IDLE;
              end else begin
                state_d = ST_FETCH;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      ST_FETCH: begin
        if (walk_q >= len_q) begin
          active_d = 1'b0;
          done_d   = 1'b1;
          kind_d   = KIND_ERROR;
          err_d    = ERR_PAST_END;
          state_d  = ST_IDLE;
        end else begin
          state_d = ST_WAIT_LB;
        end
      end

      ST_WAIT_LB: begin
        lb_d    = rdata_i;
        state_d = ST_IDLE;
        done_d  = 1'b1;
        if ((rdata_i & PREFIX_MASK) == PREFIX_MASK) begin
          if (walk_inc >= len_q) begin
            active_d = 1'b0;
            kind_d   = KIND_ERROR;
            err_d    = ERR_PTR_CUT;
          end else begin
            mem_req_o.raddr = walk_inc[ADDR_W-1:0];
            done_d          = 1'b0;
            state_d         = ST_WAIT_LO;
          end
        end else if ((rdata_i & PREFIX_MASK) != 8'h00) begin
          active_d = 1'b0;
          kind_d   = KIND_ERROR;
          err_d    = ERR_RESERVED;
        end else if (rdata_i == 8'h00) begin
          walk_d   = walk_inc;
          active_d = 1'b0;
          kind_d   = KIND_END;
          nlen_d   = built_q[7:0];
          rsm_d    = ptr_q ? resume_q : walk_inc;
        end else if (rdata_i > 8'(LABEL_LIMIT)) begin
          active_d = 1'b0;
          kind_d   = KIND_ERROR;
          err_d    = ERR_LONG_LABEL;
        end else if (label_end > {1'b0, len_q}) begin
          active_d = 1'b0;
          kind_d   = KIND_ERROR;
          err_d    = ERR_LABEL_PAST;
        end else if (name_sum > POS_W'(NAME_LIMIT)) begin
          active_d = 1'b0;
          kind_d   = KIND_ERROR;
          err_d    = ERR_LONG_NAME;
        end else begin
          built_d  = (built_q == '0) ? BUILT_W'(rdata_i) : name_sum[BUILT_W-1:0];
          walk_d   = label_end[POS_W-1:0];
          kind_d   = KIND_LABEL;
          lstart_d = walk_inc[8:0];
          llen_d   = rdata_i[5:0];
          nlen_d   = (built_q == '0) ? rdata_i : name_sum[7:0];
        end
      end

      ST_WAIT_LO: begin
        if (!ptr_q) begin
          resume_d = walk_q + POS_W'(2);
          ptr_d    = 1'b1;
        end
        if (target >= 14'(walk_q)) begin
          active_d = 1'b0;
          done_d   = 1'b1;
          kind_d   = KIND_ERROR;
          err_d    = ERR_FORWARD;
          state_d  = ST_IDLE;
        end else if (jump_q >= JUMP_W'(MAX_JUMPS)) begin
          active_d = 1'b0;
          done_d   = 1'b1;
          kind_d   = KIND_ERROR;
          err_d    = ERR_JUMPS;
          state_d  = ST_IDLE;
        end else begin
          jump_d  = jump_q + JUMP_W'(1);
          walk_d  = target[POS_W-1:0];
          state_d = ST_FETCH;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      len_q    <= '0;
      walk_q   <= '0;
      resume_q <= '0;
      ptr_q    <= 1'b0;
      jump_q   <= '0;
      built_q  <= '0;
      active_q <= 1'b0;
      lb_q     <= '0;
      done_q   <= 1'b0;
      kind_q   <= '0;
      lstart_q <= '0;
      llen_q   <= '0;
      nlen_q   <= '0;
      rsm_q    <= '0;
      err_q    <= '0;
    end else begin
      state_q  <= state_d;
      len_q    <= len_d;
      walk_q   <= walk_d;
      resume_q <= resume_d;
      ptr_q    <= ptr_d;
      jump_q   <= jump_d;
      built_q  <= built_d;
      active_q <= active_d;
      lb_q     <= lb_d;
      done_q   <= done_d;
      kind_q   <= kind_d;
      lstart_q <= lstart_d;
      llen_q   <= llen_d;
      nlen_q   <= nlen_d;
      rsm_q    <= rsm_d;
      err_q    <= err_d;
    end
  end

  assign busy            = (state_q != ST_IDLE);
  assign done_o          = done_q;
  assign kind_o          = kind_q;
  assign label_start_o   = lstart_q;
  assign label_length_o  = llen_q;
  assign name_length_o   = nlen_q;
  assign resume_offset_o = rsm_q;
  assign error_code_o    = err_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == ST_IDLE)
    else $error("item result while walk in progress");

  a_we_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.we |-> state_q == ST_IDLE)
    else $error("store write during walk");

  a_lo_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WAIT_LO |-> (lb_q & PREFIX_MASK) == PREFIX_MASK)
    else $error("pointer low byte read without pointer prefix");

  a_lb_inrange: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WAIT_LB |-> walk_q < len_q)
    else $error("label byte read past message end");

  a_jumps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    jump_q <= JUMP_W'(MAX_JUMPS))
    else $error("jump count over limit");

endmodule

// ----- tb/dns_name_decompressor_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_name_decompressor_test
// Self-checking bench for the dns name decompressor. A planner builds
// messages in the byte store (plain names, compressed names, pointer loops
// and chains, corrupted bytes, random noise), fills any byte a walk is about
// to read before the walk is issued, and queues the items. A driver sends
// them in random bursts, predicts each answer on acceptance, and a monitor
// checks every strobed result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module dns_name_decompressor_test;
  import dnsd_pkg::*;

  localparam int          ITEM_GOAL   = 550;
  localparam int          LINGER      = 20;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int          PLAN        = 0;
  localparam int          TRIAL       = 1;
  localparam int          MIRROR      = 2;

  typedef struct packed {
    req_e       req;
    logic [9:0] pos;
    logic [7:0] data;
    logic [9:0] mlen;
    logic       hold;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [8:0] label_at;
    logic [5:0] label_len;
    logic [7:0] name_len;
    logic [9:0] resume;
    logic [3:0] code;
  } answer_t;

  logic       clk_i            = 1'b0;
  logic       rst_ni           = 1'b0;
  logic       start            = 1'b0;
  logic [1:0] req_type_i       = '0;
  logic [9:0] position_i       = '0;
  logic [7:0] byte_value_i     = '0;
  logic [9:0] message_length_i = '0;
  logic       busy;
  logic       done_o;
  logic [1:0] kind_o;
  logic [8:0] label_start_o;
  logic [5:0] label_length_o;
  logic [7:0] name_length_o;
  logic [9:0] resume_offset_o;
  logic [3:0] error_code_o;

  dns_name_decompressor dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .req_type_i       (req_type_i),
    .position_i       (position_i),
    .byte_value_i     (byte_value_i),
    .message_length_i (message_length_i),
    .done_o           (done_o),
    .kind_o           (kind_o),
    .label_start_o    (label_start_o),
    .label_length_o   (label_length_o),
    .name_length_o    (name_length_o),
    .resume_offset_o  (resume_offset_o),
    .error_code_o     (error_code_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // decoder state, one copy per slot: planner, planner scratch, checker
  logic [7:0]         msg_mem     [3][MESSAGE_BYTES];
  bit                 msg_loaded  [3][MESSAGE_BYTES];
  logic [POS_W-1:0]   msg_len     [3];
  logic [POS_W-1:0]   walk_at     [3];
  logic [POS_W-1:0]   resume_mark [3];
  logic [JUMP_W-1:0]  hops_used   [3];
  logic [BUILT_W-1:0] built_len   [3];
  bit                 ptr_seen    [3];
  bit                 decoding    [3];
  bit                 blank_hit   [3];
  int unsigned        blank_addr  [3];

  item_t       items_todo[$];
  answer_t     answers_due[$];
  item_t       shown;
  bit          hold_pending = 1'b0;
  int unsigned requests_planned = 0;
  int unsigned mismatches = 0;
  int unsigned answered = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned cycle_count = 0;

  function automatic void clear_slot(input int s);
    for (int i = 0; i < MESSAGE_BYTES; i++) begin
      msg_mem[s][i]    = '0;
      msg_loaded[s][i] = 1'b0;
    end
    msg_len[s]     = '0;
    walk_at[s]     = '0;
    resume_mark[s] = '0;
    hops_used[s]   = '0;
    built_len[s]   = '0;
    ptr_seen[s]    = 1'b0;
    decoding[s]    = 1'b0;
    blank_hit[s]   = 1'b0;
  endfunction

  function automatic void copy_slot(input int dst, input int src);
    for (int i = 0; i < MESSAGE_BYTES; i++) begin
      msg_mem[dst][i]    = msg_mem[src][i];
      msg_loaded[dst][i] = msg_loaded[src][i];
    end
    msg_len[dst]     = msg_len[src];
    walk_at[dst]     = walk_at[src];
    resume_mark[dst] = resume_mark[src];
    hops_used[dst]   = hops_used[src];
    built_len[dst]   = built_len[src];
    ptr_seen[dst]    = ptr_seen[src];
    decoding[dst]    = decoding[src];
  endfunction

  function automatic logic [7:0] peek(input int s, input int unsigned a);
    if (!msg_loaded[s][a]) begin
      blank_hit[s]  = 1'b1;
      blank_addr[s] = a;
    end
    return msg_mem[s][a];
  endfunction

  function automatic answer_t give_up(input int s, input error_e code);
    answer_t ans;
    ans         = '0;
    decoding[s] = 1'b0;
    ans.kind    = KIND_ERROR;
    ans.code    = code;
    return ans;
  endfunction

  function automatic answer_t decode_step(input int s, input item_t it);
    answer_t     ans;
    int unsigned pos;
    int unsigned hop;
    int unsigned v;
    logic [7:0]  lb;
    logic [13:0] tgt;
    bit          walking;
    ans          = '0;
    blank_hit[s] = 1'b0;
    case (it.req)
      REQ_LOAD: begin
        if (it.pos < MESSAGE_BYTES) begin
          msg_mem[s][it.pos[ADDR_W-1:0]]    = it.data;
          msg_loaded[s][it.pos[ADDR_W-1:0]] = 1'b1;
        end
        ans.kind = KIND_ACK;
      end
      REQ_START: begin
        msg_len[s]     = (it.mlen > MESSAGE_BYTES) ? MESSAGE_BYTES[POS_W-1:0] : it.mlen;
        walk_at[s]     = it.pos;
        resume_mark[s] = '0;
        ptr_seen[s]    = 1'b0;
        hops_used[s]   = '0;
        built_len[s]   = '0;
        decoding[s]    = 1'b1;
        ans.kind       = KIND_ACK;
      end
      REQ_NEXT: begin
        if (!decoding[s]) begin
          ans = give_up(s, ERR_IDLE);
        end else begin
          hop     = 0;
          walking = 1'b1;
          while (walking) begin
            walking = 1'b0;
            pos     = walk_at[s];
            if (hop > MAX_JUMPS + 1) begin
              ans = give_up(s, ERR_JUMPS);
            end else if (pos >= msg_len[s]) begin
              ans = give_up(s, ERR_PAST_END);
            end else begin
              lb = peek(s, pos);
              if ((lb & PREFIX_MASK) == PREFIX_MASK) begin
                if (pos + 1 >= msg_len[s]) begin
                  ans = give_up(s, ERR_PTR_CUT);
                end else begin
                  tgt = {lb[5:0], peek(s, pos + 1)} & TARGET_MASK;
                  if (!ptr_seen[s]) begin
                    v              = pos + 2;
                    resume_mark[s] = v[POS_W-1:0];
                    ptr_seen[s]    = 1'b1;
                  end
                  if (tgt >= pos) begin
                    ans = give_up(s, ERR_FORWARD);
                  end else if (hops_used[s] >= MAX_JUMPS) begin
                    ans = give_up(s, ERR_JUMPS);
                  end else begin
                    hops_used[s] = hops_used[s] + 1'b1;
                    walk_at[s]   = tgt[POS_W-1:0];
                    hop++;
                    walking = 1'b1;
                  end
                end
              end else if ((lb & PREFIX_MASK) != 8'h00) begin
                ans = give_up(s, ERR_RESERVED);
              end else if (lb == 8'h00) begin
                v           = ptr_seen[s] ? resume_mark[s] : pos + 1;
                ans.kind    = KIND_END;
                ans.name_len = built_len[s][7:0];
                ans.resume  = v[9:0];
                v           = pos + 1;
                walk_at[s]  = v[POS_W-1:0];
                decoding[s] = 1'b0;
              end else if (lb > LABEL_LIMIT) begin
                ans = give_up(s, ERR_LONG_LABEL);
              end else if (pos + 1 + lb > msg_len[s]) begin
                ans = give_up(s, ERR_LABEL_PAST);
              end else if (built_len[s] + lb + 1 > NAME_LIMIT) begin
                ans = give_up(s, ERR_LONG_NAME);
              end else begin
                v            = (built_len[s] == 0) ? lb : built_len[s] + 1 + lb;
                built_len[s] = v[BUILT_W-1:0];
                v            = pos + 1 + lb;
                walk_at[s]   = v[POS_W-1:0];
                v            = pos + 1;
                ans.kind      = KIND_LABEL;
                ans.label_at  = v[8:0];
                ans.label_len = lb[5:0];
                ans.name_len  = built_len[s][7:0];
              end
            end
          end
        end
      end
      default: ans.kind = KIND_ACK;
    endcase
    return ans;
  endfunction

  function automatic item_t make_item(input req_e r, input int unsigned p,
                                      input int unsigned d, input int unsigned l);
    item_t it;
    it.req  = r;
    it.pos  = p[9:0];
    it.data = d[7:0];
    it.mlen = l[9:0];
    it.hold = 1'b0;
    return it;
  endfunction

  task automatic queue_raw(input item_t it);
    void'(decode_step(PLAN, it));
    it.hold      = hold_pending;
    hold_pending = 1'b0;
    items_todo   = {items_todo, it};
    if (it.req == REQ_START || it.req == REQ_NEXT ||
        (it.req == REQ_LOAD && it.pos < MESSAGE_BYTES)) begin
      requests_planned++;
    end
  endtask

  task automatic send_load(input int unsigned a, input int unsigned d);
    queue_raw(make_item(REQ_LOAD, a, d, $urandom_range(0, 1023)));
  endtask

  task automatic send_start(input int unsigned p, input int unsigned l);
    queue_raw(make_item(REQ_START, p, $urandom_range(0, 255), l));
  endtask

  // any byte the walk would read unloaded gets loaded first
  task automatic send_next();
    item_t it;
    it = make_item(REQ_NEXT, $urandom_range(0, 1023), $urandom_range(0, 255),
                   $urandom_range(0, 1023));
    copy_slot(TRIAL, PLAN);
    void'(decode_step(TRIAL, it));
    while (blank_hit[TRIAL]) begin
      send_load(blank_addr[TRIAL], $urandom_range(0, 255));
      copy_slot(TRIAL, PLAN);
      void'(decode_step(TRIAL, it));
    end
    queue_raw(it);
  endtask

  task automatic finish_name(input int unsigned max_steps);
    int unsigned n;
    n = 0;
    while (decoding[PLAN] && n < max_steps) begin
      if ($urandom_range(0, 19) == 0) begin
        send_load($urandom_range(0, MESSAGE_BYTES - 1), $urandom_range(0, 255));
      end
      send_next();
      n++;
    end
  endtask

  task automatic put_label(inout int unsigned at, input int unsigned len);
    send_load(at, len);
    for (int unsigned i = 1; i <= len; i++) begin
      send_load(at + i, $urandom_range(0, 255));
    end
    at += len + 1;
  endtask

  task automatic put_pointer(inout int unsigned at, input int unsigned tgt);
    send_load(at, 32'hc0 | (tgt >> 8));
    send_load(at + 1, tgt & 32'hff);
    at += 2;
  endtask

  function automatic int unsigned pick_len(input int unsigned at);
    if ($urandom_range(0, 7) == 0 && at + 128 <= MESSAGE_BYTES) begin
      return $urandom_range(20, 63);
    end
    return $urandom_range(1, 6);
  endfunction

  // plain name followed by names that end in a pointer into earlier names
  task automatic well_formed_run();
    int unsigned base;
    int unsigned at;
    int unsigned mlen;
    int unsigned heads[$];
    int unsigned marks[$];
    int unsigned fresh[$];
    base = $urandom_range(0, 300);
    at   = base;
    repeat ($urandom_range(0, 4)) begin
      marks = {marks, at};
      put_label(at, pick_len(at));
    end
    marks = {marks, at};
    send_load(at, 0);
    at++;
    heads = {heads, base};
    repeat ($urandom_range(1, 2)) begin
      heads = {heads, at};
      repeat ($urandom_range(0, 2)) begin
        fresh = {fresh, at};
        put_label(at, pick_len(at));
      end
      put_pointer(at, marks[$urandom_range(0, marks.size() - 1)]);
      foreach (fresh[i]) marks = {marks, fresh[i]};
      fresh.delete();
    end
    case ($urandom_range(0, 9))
      0, 1: mlen = $urandom_range(at, 1023);
      2: mlen = $urandom_range(0, at);
      default: mlen = at;
    endcase
    if ($urandom_range(0, 4) == 0) begin
      send_load($urandom_range(base, at - 1), $urandom_range(0, 255));
    end
    foreach (heads[i]) begin
      send_start(heads[i], mlen);
      finish_name(($urandom_range(0, 9) == 0) ? 1 : 40);
    end
  endtask

  // label followed by a pointer back to itself: long name or jump limit
  task automatic loop_run();
    int unsigned len;
    int unsigned base;
    int unsigned at;
    case ($urandom_range(0, 2))
      0: len = 1;
      1: len = LABEL_LIMIT;
      default: len = $urandom_range(1, LABEL_LIMIT);
    endcase
    base = $urandom_range(0, MESSAGE_BYTES - len - 4);
    at   = base;
    put_label(at, len);
    put_pointer(at, base);
    send_start(base, ($urandom_range(0, 3) == 0) ? $urandom_range(at, 1023) : at);
    finish_name(40);
  endtask

  // chain of pointers, each to the one before, ending at a one-label name
  task automatic chain_run(input int unsigned hops);
    int unsigned base;
    int unsigned at;
    int unsigned prev;
    base = $urandom_range(0, MESSAGE_BYTES - 4 - 2 * hops);
    at   = base;
    put_label(at, 1);
    send_load(at, 0);
    at++;
    prev = base;
    repeat (hops) begin
      put_pointer(at, prev);
      prev = at - 2;
    end
    send_start(prev, at);
    finish_name(40);
  endtask

  task automatic noise_run();
    repeat ($urandom_range(8, 30)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_load(($urandom_range(0, 6) == 0) ? $urandom_range(512, 1023) :
                                $urandom_range(0, 511), $urandom_range(0, 255));
        4, 5: send_start(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) :
                         $urandom_range(0, 511), $urandom_range(0, 1023));
        6: queue_raw(make_item(REQ_NONE, $urandom_range(0, 1023), $urandom_range(0, 255),
                               $urandom_range(0, 1023)));
        default: send_next();
      endcase
    end
  endtask

  task automatic report_diff(input string field, input int unsigned got,
                             input int unsigned want);
    mismatches++;
    if (mismatches <= 40) begin
      $display("result %0d: %s is %0d, expected %0d", answered, field, got, want);
    end
  endtask

  initial begin
    clear_slot(PLAN);
    clear_slot(MIRROR);

    // directed items
    send_next();
    queue_raw(make_item(REQ_NONE, 1023, 255, 1023));
    send_load(1023, 8'h5a);
    send_load(512, 8'ha5);
    send_load(0, 1);
    send_load(1, 8'hff);
    send_load(2, 0);
    send_load(3, 8'hc0);
    send_load(4, 0);
    send_start(3, 1023);
    send_next();
    send_next();
    send_next();
    send_start(700, 5);
    send_next();
    hold_pending = 1'b1;
    send_start(0, 5);
    send_next();
    send_load(2, 0);
    send_start(3, 4);
    send_next();
    send_load(5, 8'hc0);
    send_load(6, 6);
    send_start(5, 7);
    send_next();
    send_load(7, 8'h80);
    send_start(7, 8);
    send_next();
    send_start(0, 1);
    send_next();

    // random part
    hold_pending = 1'b1;
    chain_run(MAX_JUMPS);
    chain_run(MAX_JUMPS + 1);
    while (requests_planned < ITEM_GOAL) begin
      if ($urandom_range(0, 9) == 0) hold_pending = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: well_formed_run();
        6: loop_run();
        7: chain_run($urandom_range(1, MAX_JUMPS + 1));
        default: noise_run();
      endcase
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (items_todo.size() != 0 || start || answers_due.size() != 0) @(posedge clk_i);
    repeat (LINGER) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // sender: bursts of items with random gaps, start held while busy
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start            <= 1'b0;
      req_type_i       <= REQ_LOAD;
      position_i       <= '0;
      byte_value_i     <= '0;
      message_length_i <= '0;
    end else begin
      if (start && !busy) begin
        answers_due = {answers_due, decode_step(MIRROR, shown)};
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (items_todo.size() == 0 ||
                     (items_todo[0].hold && answers_due.size() != 0)) begin
          start <= 1'b0;
        end else begin
          shown            = items_todo.pop_front();
          req_type_i       <= shown.req;
          position_i       <= shown.pos;
          byte_value_i     <= shown.data;
          message_length_i <= shown.mlen;
          start            <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    answer_t want;
    if (rst_ni && done_o) begin
      if (answers_due.size() == 0) begin
        report_diff("result with no item outstanding, kind", kind_o, 0);
      end else begin
        want = answers_due.pop_front();
        if (kind_o !== want.kind) report_diff("kind", kind_o, want.kind);
        if (label_start_o !== want.label_at)
          report_diff("label_start", label_start_o, want.label_at);
        if (label_length_o !== want.label_len)
          report_diff("label_length", label_length_o, want.label_len);
        if (name_length_o !== want.name_len)
          report_diff("name_length", name_length_o, want.name_len);
        if (resume_offset_o !== want.resume)
          report_diff("resume_offset", resume_offset_o, want.resume);
        if (error_code_o !== want.code)
          report_diff("error_code", error_code_o, want.code);
        answered++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule

// ----- filelist.f -----
design/dnsd_pkg.sv
design/dnsd_store.sv
design/dnsd_walker.sv
design/dns_name_decompressor.sv
tb/dns_name_decompressor_test.sv
